>>> hdl/ffpa_pkg.sv
// Shared types and constants of the first-fit page bitmap allocator.
`timescale 1ns / 1ps
`default_nettype none

package ffpa_pkg;

  // Fixed field widths of the request, result and configuration ports.
  localparam int unsigned OP_W      = 1;
  localparam int unsigned START_W   = 12;
  localparam int unsigned COUNT_W   = 13;
  localparam int unsigned MANAGED_W = 13;
  localparam int unsigned STATUS_W  = 2;
  localparam int unsigned BASE_W    = 12;

  // Reset value of the managed page count register.
  localparam logic [MANAGED_W-1:0] MANAGED_RESET = 13'd4096;

  // Request operation codes.
  localparam logic [OP_W-1:0] OP_ALLOC = 1'b0;
  localparam logic [OP_W-1:0] OP_FREE  = 1'b1;

  // Result status codes.
  typedef enum logic [STATUS_W-1:0] {
    STATUS_OK         = 2'd0,
    STATUS_NO_FREE    = 2'd1,
    STATUS_NO_RUN     = 2'd2,
    STATUS_ZERO_COUNT = 2'd3
  } status_e;

endpackage

`default_nettype wire

>>> hdl/first_fit_page_bitmap_allocator.sv
// Top level of the first-fit page bitmap allocator.
//
// One usage bit per page is kept in a single-port-read, single-port-write map memory of
// MAP_WORD_BITS-bit words. An allocate request scans the map one word per cycle from page 0
// up to the managed page count and stops at the first word that completes a run of the
// requested length; it then rewrites every word the run covers, one word per cycle. The scan
// covers at most 128 words with default parameters. A free request rewrites the words it
// covers. A zero-length or out-of-range free and an allocate with a managed count of zero
// answer on the cycle after the request. busy_o is high while a request is under way; each
// request yields exactly one result, shown for one cycle with result_valid_o, and the
// receiver cannot hold it off. The map reads as all free after reset, with no clearing
// pass. The managed page count is written through the cfg channel while the block is idle.
`timescale 1ns / 1ps
`default_nettype none

module first_fit_page_bitmap_allocator #(
  parameter int unsigned PAGE_COUNT_MAX = 4096,
  parameter int unsigned MAP_WORD_BITS  = 32
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             start_i,
  output logic                             busy_o,
  input  logic [ffpa_pkg::OP_W-1:0]        operation_i,
  input  logic [ffpa_pkg::START_W-1:0]     start_page_i,
  input  logic [ffpa_pkg::COUNT_W-1:0]     page_count_i,
  input  logic                             cfg_valid_i,
  output logic                             cfg_ready_o,
  input  logic [ffpa_pkg::MANAGED_W-1:0]   cfg_data_i,
  output logic                             result_valid_o,
  output logic [ffpa_pkg::STATUS_W-1:0]    status_o,
  output logic [ffpa_pkg::BASE_W-1:0]      base_page_o
);

  import ffpa_pkg::*;

  localparam int unsigned DEPTH = (PAGE_COUNT_MAX + MAP_WORD_BITS - 1) / MAP_WORD_BITS;
  localparam int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned WL    = $clog2(MAP_WORD_BITS);
  localparam int unsigned PW    = $clog2(PAGE_COUNT_MAX) + 1;
  localparam int unsigned CW    = (PW > COUNT_W) ? PW : COUNT_W;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_MARK
  } state_e;

  state_e               state_q, state_d;
  logic [MANAGED_W-1:0] managed_q, managed_d;
  logic [CW-1:0]        limit_q, limit_d;
  logic [CW-1:0]        count_q, count_d;
  logic [CW-1:0]        lo_q, lo_d;
  logic [CW-1:0]        hi_q, hi_d;
  logic [CW-1:0]        run_q, run_d;
  logic                 any_free_q, any_free_d;
  logic                 set_q, set_d;
  logic                 issue_q, issue_d;
  logic                 pend_q, pend_d;
  logic [AW-1:0]        rd_word_q, rd_word_d;
  logic [AW-1:0]        pend_word_q, pend_word_d;
  logic [AW-1:0]        last_word_q, last_word_d;
  logic [CW-1:0]        base_q, base_d;
  status_e              status_q, status_d;
  logic                 result_valid_q, result_valid_d;

  logic                     ram_rd_en;
  logic [MAP_WORD_BITS-1:0] ram_rd_data;
  logic                     ram_wr_en;
  logic [MAP_WORD_BITS-1:0] ram_wr_data;
  logic [MAP_WORD_BITS-1:0] range_mask;

  logic [CW-1:0]        limit_c;
  logic [CW-1:0]        start_c;
  logic [CW-1:0]        count_c;
  logic [CW:0]          free_end_c;
  logic [CW-1:0]        free_hi_c;
  logic [CW-1:0]        word_base_c;
  logic [CW-1:0]        hit_page_c;
  logic [CW-1:0]        alloc_base_c;

  logic                 sc_hit;
  logic [WL-1:0]        sc_hit_idx;
  logic                 sc_any_free;
  logic [CW-1:0]        sc_run;

  function automatic logic [AW-1:0] word_of(input logic [CW-1:0] page);
    logic [CW-1:0] shifted;
    shifted = page >> WL;
    return shifted[AW-1:0];
  endfunction

  // Request decoding: effective limit and the clipped free range.
  always_comb begin
    limit_c    = (CW'(managed_q) > CW'(PAGE_COUNT_MAX)) ? CW'(PAGE_COUNT_MAX)
                                                        : CW'(managed_q);
    start_c    = CW'(start_page_i);
    count_c    = CW'(page_count_i);
    free_end_c = {1'b0, start_c} + {1'b0, count_c};
    free_hi_c  = (free_end_c > {1'b0, limit_c}) ? limit_c : free_end_c[CW-1:0];
  end

  // Page addresses of the word whose data is arriving and of the run found in it.
  always_comb begin
    word_base_c  = CW'(pend_word_q) << WL;
    hit_page_c   = word_base_c + CW'(sc_hit_idx);
    alloc_base_c = hit_page_c - count_q + CW'(1);
  end

  // Bits of the arriving word that fall inside the range being marked or cleared.
  always_comb begin
    for (int i = 0; i < MAP_WORD_BITS; i++) begin
      range_mask[i] = ((word_base_c + CW'(i)) >= lo_q) && ((word_base_c + CW'(i)) < hi_q);
    end
  end

  ffpa_map_ram #(
    .WORD_BITS (MAP_WORD_BITS),
    .DEPTH     (DEPTH),
    .AW        (AW)
  ) u_map (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .rd_en_i   (ram_rd_en),
    .rd_addr_i (rd_word_q),
    .rd_data_o (ram_rd_data),
    .wr_en_i   (ram_wr_en),
    .wr_addr_i (pend_word_q),
    .wr_data_i (ram_wr_data)
  );

  ffpa_word_scan #(
    .WORD_BITS (MAP_WORD_BITS),
    .WL        (WL),
    .CW        (CW)
  ) u_scan (
    .word_i      (ram_rd_data),
    .word_base_i (word_base_c),
    .limit_i     (limit_q),
    .run_i       (run_q),
    .count_i     (count_q),
    .hit_o       (sc_hit),
    .hit_idx_o   (sc_hit_idx),
    .any_free_o  (sc_any_free),
    .run_o       (sc_run)
  );

  // Read-modify-write of the arriving word while marking or clearing.
  assign ram_wr_en   = (state_q == S_MARK) && pend_q;
  assign ram_wr_data = set_q ? (ram_rd_data | range_mask) : (ram_rd_data & ~range_mask);
  assign ram_rd_en   = ((state_q == S_SCAN) || (state_q == S_MARK)) && issue_q;

  // Sequencer: request intake, word scan, run marking and result.
  always_comb begin
    state_d        = state_q;
    managed_d      = managed_q;
    limit_d        = limit_q;
    count_d        = count_q;
    lo_d           = lo_q;
    hi_d           = hi_q;
    run_d          = run_q;
    any_free_d     = any_free_q;
    set_d          = set_q;
    issue_d        = issue_q;
    pend_d         = 1'b0;
    rd_word_d      = rd_word_q;
    pend_word_d    = pend_word_q;
    last_word_d    = last_word_q;
    base_d         = base_q;
    status_d       = status_q;
    result_valid_d = 1'b0;

    // Read issue: one word per cycle up to the last word of the range.
    if (ram_rd_en) begin
      pend_d      = 1'b1;
      pend_word_d = rd_word_q;
      if (rd_word_q == last_word_q) begin
        issue_d = 1'b0;
      end else begin
        rd_word_d = rd_word_q + AW'(1);
      end
    end

    unique case (state_q)
      S_IDLE: begin
        if (cfg_valid_i) begin
          managed_d = cfg_data_i;
        end
        if (start_i) begin
          count_d = count_c;
          limit_d = limit_c;
          base_d  = '0;
          pend_d  = 1'b0;
          if (operation_i == OP_FREE) begin
            if (start_c >= free_hi_c) begin
              status_d       = STATUS_OK;
              result_valid_d = 1'b1;
            end else begin
              lo_d        = start_c;
              hi_d        = free_hi_c;
              set_d       = 1'b0;
              rd_word_d   = word_of(start_c);
              last_word_d = word_of(free_hi_c - CW'(1));
              issue_d     = 1'b1;
              state_d     = S_MARK;
            end
          end else begin
            if (limit_c == '0) begin
              status_d       = STATUS_NO_FREE;
              result_valid_d = 1'b1;
            end else begin
              run_d       = '0;
              any_free_d  = 1'b0;
              rd_word_d   = '0;
              last_word_d = word_of(limit_c - CW'(1));
              issue_d     = 1'b1;
              state_d     = S_SCAN;
            end
          end
        end
      end

      S_SCAN: begin
        if (pend_q) begin
          if ((count_q == '0) && sc_any_free) begin
            status_d       = STATUS_ZERO_COUNT;
            result_valid_d = 1'b1;
            issue_d        = 1'b0;
            pend_d         = 1'b0;
            state_d        = S_IDLE;
          end else if ((count_q != '0) && sc_hit) begin
            // Run found: rewrite every word from its first page to this word.
            lo_d        = alloc_base_c;
            hi_d        = hit_page_c + CW'(1);
            base_d      = alloc_base_c;
            set_d       = 1'b1;
            rd_word_d   = word_of(alloc_base_c);
            last_word_d = pend_word_q;
            issue_d     = 1'b1;
            pend_d      = 1'b0;
            state_d     = S_MARK;
          end else begin
            run_d      = sc_run;
            any_free_d = any_free_q | sc_any_free;
            if (pend_word_q == last_word_q) begin
              status_d       = (any_free_q | sc_any_free) ? STATUS_NO_RUN : STATUS_NO_FREE;
              result_valid_d = 1'b1;
              issue_d        = 1'b0;
              pend_d         = 1'b0;
              state_d        = S_IDLE;
            end
          end
        end
      end

      S_MARK: begin
        if (pend_q && !issue_q) begin
          status_d       = STATUS_OK;
          result_valid_d = 1'b1;
          state_d        = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // State and registered outputs.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= S_IDLE;
      managed_q      <= MANAGED_RESET;
      limit_q        <= '0;
      count_q        <= '0;
      lo_q           <= '0;
      hi_q           <= '0;
      run_q          <= '0;
      any_free_q     <= 1'b0;
      set_q          <= 1'b0;
      issue_q        <= 1'b0;
      pend_q         <= 1'b0;
      rd_word_q      <= '0;
      pend_word_q    <= '0;
      last_word_q    <= '0;
      base_q         <= '0;
      status_q       <= STATUS_OK;
      result_valid_q <= 1'b0;
    end else begin
      state_q        <= state_d;
      managed_q      <= managed_d;
      limit_q        <= limit_d;
      count_q        <= count_d;
      lo_q           <= lo_d;
      hi_q           <= hi_d;
      run_q          <= run_d;
      any_free_q     <= any_free_d;
      set_q          <= set_d;
      issue_q        <= issue_d;
      pend_q         <= pend_d;
      rd_word_q      <= rd_word_d;
      pend_word_q    <= pend_word_d;
      last_word_q    <= last_word_d;
      base_q         <= base_d;
      status_q       <= status_d;
      result_valid_q <= result_valid_d;
    end
  end

  assign busy_o         = (state_q != S_IDLE);
  assign cfg_ready_o    = (state_q == S_IDLE);
  assign result_valid_o = result_valid_q;
  assign status_o       = status_q;
  assign base_page_o    = base_q[BASE_W-1:0];

endmodule

`default_nettype wire

>>> hdl/ffpa_map_ram.sv
// Page usage map storage: one synchronous memory word per group of pages.
`timescale 1ns / 1ps
`default_nettype none

module ffpa_map_ram #(
  parameter int unsigned WORD_BITS = 32,
  parameter int unsigned DEPTH     = 128,
  parameter int unsigned AW        = 7
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 rd_en_i,
  input  logic [AW-1:0]        rd_addr_i,
  output logic [WORD_BITS-1:0] rd_data_o,
  input  logic                 wr_en_i,
  input  logic [AW-1:0]        wr_addr_i,
  input  logic [WORD_BITS-1:0] wr_data_i
);

  logic [WORD_BITS-1:0] mem [DEPTH];
  logic [DEPTH-1:0]     vld_q;
  logic [WORD_BITS-1:0] rd_data_q;
  logic                 rd_vld_q;

  // Memory array with a registered read port.
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_data_q <= mem[rd_addr_i];
    end
  end

  // Per-word valid bits; a word never written reads as all pages free.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q    <= '0;
      rd_vld_q <= 1'b0;
    end else begin
      if (wr_en_i) begin
        vld_q[wr_addr_i] <= 1'b1;
      end
      if (rd_en_i) begin
        rd_vld_q <= vld_q[rd_addr_i];
      end
    end
  end

  assign rd_data_o = rd_vld_q ? rd_data_q : '0;

endmodule

`default_nettype wire

>>> hdl/ffpa_word_scan.sv
// Free-run search over one map word, carrying the run length across words.
`timescale 1ns / 1ps
`default_nettype none

module ffpa_word_scan #(
  parameter int unsigned WORD_BITS = 32,
  parameter int unsigned WL        = 5,
  parameter int unsigned CW        = 13
) (
  input  logic [WORD_BITS-1:0] word_i,
  input  logic [CW-1:0]        word_base_i,
  input  logic [CW-1:0]        limit_i,
  input  logic [CW-1:0]        run_i,
  input  logic [CW-1:0]        count_i,
  output logic                 hit_o,
  output logic [WL-1:0]        hit_idx_o,
  output logic                 any_free_o,
  output logic [CW-1:0]        run_o
);

  logic [WORD_BITS-1:0] used;
  logic [WORD_BITS-1:0] seen;
  logic [WL-1:0]        last_pos [WORD_BITS];
  logic [CW-1:0]        run_len  [WORD_BITS];

  // Pages at or beyond the limit count as used.
  always_comb begin
    for (int i = 0; i < WORD_BITS; i++) begin
      used[i] = word_i[i] || ((word_base_i + CW'(i)) >= limit_i);
    end
  end

  // Length of the free run that ends at each bit, found from the nearest used bit below it.
  always_comb begin
    for (int i = 0; i < WORD_BITS; i++) begin
      seen[i]     = 1'b0;
      last_pos[i] = '0;
      for (int j = 0; j <= i; j++) begin
        if (used[j]) begin
          seen[i]     = 1'b1;
          last_pos[i] = WL'(j);
        end
      end
      run_len[i] = seen[i] ? (CW'(i) - CW'(last_pos[i])) : (run_i + CW'(i + 1));
    end
  end

  // Lowest bit at which the run reaches the requested count.
  always_comb begin
    hit_o     = 1'b0;
    hit_idx_o = '0;
    for (int i = WORD_BITS - 1; i >= 0; i--) begin
      if (run_len[i] >= count_i) begin
        hit_o     = 1'b1;
        hit_idx_o = WL'(i);
      end
    end
  end

  assign any_free_o = ~&used;
  assign run_o      = run_len[WORD_BITS-1];

endmodule

`default_nettype wire

>>> hdl/ffpa_checker.sv
// Port-level checks of the allocator and their binding to the top level.
`timescale 1ns / 1ps
`default_nettype none

module ffpa_checker (
  input logic                           clk_i,
  input logic                           rst_ni,
  input logic                           start_i,
  input logic                           busy_o,
  input logic                           result_valid_o,
  input logic [ffpa_pkg::STATUS_W-1:0]  status_o,
  input logic [ffpa_pkg::BASE_W-1:0]    base_page_o
);

  import ffpa_pkg::*;

  // A result follows either an accepted request or a cycle of work.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> ($past(start_i && !busy_o) || $past(busy_o)))
    else $error("result without a request in progress");

  // The block is idle again when it shows a result.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> !busy_o)
    else $error("result shown while still busy");

  // A failed allocate carries no base page.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && (status_o != STATUS_OK)) |-> (base_page_o == '0))
    else $error("nonzero base page on a failed request");

  // An accepted request either starts work or answers on the next cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |=> (busy_o || result_valid_o))
    else $error("accepted request neither started nor answered");

endmodule

bind first_fit_page_bitmap_allocator ffpa_checker u_ffpa_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .start_i        (start_i),
  .busy_o         (busy_o),
  .result_valid_o (result_valid_o),
  .status_o       (status_o),
  .base_page_o    (base_page_o)
);

`default_nettype wire

>>> sim/first_fit_page_bitmap_allocator_checker.sv
// Checker that predicts and compares the results of the first-fit page allocator.
`timescale 1ns / 1ps

module first_fit_page_bitmap_allocator_checker #(
  parameter int unsigned PAGE_COUNT_MAX = 4096
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           start_i,
  input  logic                           busy_i,
  input  logic [ffpa_pkg::OP_W-1:0]      operation_i,
  input  logic [ffpa_pkg::START_W-1:0]   start_page_i,
  input  logic [ffpa_pkg::COUNT_W-1:0]   page_count_i,
  input  logic                           cfg_valid_i,
  input  logic                           cfg_ready_i,
  input  logic [ffpa_pkg::MANAGED_W-1:0] cfg_data_i,
  input  logic                           result_valid_i,
  input  logic [ffpa_pkg::STATUS_W-1:0]  status_i,
  input  logic [ffpa_pkg::BASE_W-1:0]    base_page_i,
  output int unsigned                    mismatches_o,
  output int unsigned                    outstanding_o
);

  import ffpa_pkg::*;

  typedef struct packed {
    status_e           status;
    logic [BASE_W-1:0] base;
  } answer_t;

  // Shadow of the usage map (1 = used) and of the managed page count.
  logic [PAGE_COUNT_MAX-1:0] used_pages;
  logic [MANAGED_W-1:0]      pages_managed;
  answer_t                   answers_due[$];
  int unsigned               mismatches;

  // Applies one request to the shadow map and returns the answer it must produce.
  function automatic answer_t serve_request(input logic [OP_W-1:0]    op,
                                            input logic [START_W-1:0] first_page,
                                            input logic [COUNT_W-1:0] page_count);
    int unsigned scan_limit;
    int unsigned lowest_free;
    int unsigned run_base;
    int unsigned run_length;
    bit          run_found;
    answer_t     answer;

    scan_limit   = (pages_managed > PAGE_COUNT_MAX) ? PAGE_COUNT_MAX : pages_managed;
    answer.status = STATUS_OK;
    answer.base   = '0;

    // A free clears pages up to the managed count and always reports success.
    if (op == OP_FREE) begin
      for (int unsigned i = 0; i < page_count; i++) begin
        if (first_page + i >= scan_limit) break;
        used_pages[first_page + i] = 1'b0;
      end
      return answer;
    end

    // An allocate first looks for any free page at all.
    lowest_free = scan_limit;
    for (int unsigned p = 0; p < scan_limit; p++) begin
      if (!used_pages[p]) begin
        lowest_free = p;
        break;
      end
    end

    if (lowest_free >= scan_limit) begin
      answer.status = STATUS_NO_FREE;
    end else if (page_count == 0) begin
      answer.status = STATUS_ZERO_COUNT;
    end else begin
      // First fit: a used page restarts the run just above it.
      run_base   = lowest_free;
      run_length = 0;
      run_found  = 1'b0;
      for (int unsigned p = lowest_free; p < scan_limit; p++) begin
        if (used_pages[p]) begin
          run_base   = p + 1;
          run_length = 0;
        end else begin
          run_length++;
          if (run_length == page_count) begin
            run_found = 1'b1;
            break;
          end
        end
      end
      if (run_found) begin
        for (int unsigned i = 0; i < page_count; i++) used_pages[run_base + i] = 1'b1;
        answer.base = run_base[BASE_W-1:0];
      end else begin
        answer.status = STATUS_NO_RUN;
      end
    end
    return answer;
  endfunction

  // Results are compared before the request transfer of the same edge is predicted.
  always @(posedge clk_i or negedge rst_ni) begin
    answer_t expected_answer;
    if (!rst_ni) begin
      used_pages    = '0;
      pages_managed = MANAGED_RESET;
      answers_due.delete();
      mismatches    = 0;
      mismatches_o  <= 0;
      outstanding_o <= 0;
    end else begin
      if (result_valid_i) begin
        if (answers_due.size() == 0) begin
          mismatches++;
          $display("%0t: unexpected result: status %0d base_page %0d", $time, status_i,
                   base_page_i);
        end else begin
          expected_answer = answers_due.pop_front();
          if (status_i !== expected_answer.status) begin
            mismatches++;
            $display("%0t: status mismatch: expected %0d actual %0d", $time,
                     expected_answer.status, status_i);
          end
          if (base_page_i !== expected_answer.base) begin
            mismatches++;
            $display("%0t: base_page mismatch: expected %0d actual %0d", $time,
                     expected_answer.base, base_page_i);
          end
        end
      end

      if (cfg_valid_i && cfg_ready_i) pages_managed = cfg_data_i;

      if (start_i && !busy_i) begin
        answers_due.push_back(serve_request(operation_i, start_page_i, page_count_i));
      end

      mismatches_o  <= mismatches;
      outstanding_o <= answers_due.size();
    end
  end

endmodule

>>> sim/first_fit_page_bitmap_allocator_tb.sv
// Stimulus and verdict for the first-fit page allocator, checked by a separate checker.
`timescale 1ns / 1ps

module first_fit_page_bitmap_allocator_tb;
  import ffpa_pkg::*;

  localparam int unsigned PAGE_COUNT_MAX = 4096;
  localparam int unsigned DRAIN_CYCLES   = 300;

  logic                 clk_i = 1'b0;
  logic                 rst_ni;
  logic                 start_i;
  logic                 busy_o;
  logic [OP_W-1:0]      operation_i;
  logic [START_W-1:0]   start_page_i;
  logic [COUNT_W-1:0]   page_count_i;
  logic                 cfg_valid_i;
  logic                 cfg_ready_o;
  logic [MANAGED_W-1:0] cfg_data_i;
  logic                 result_valid_o;
  logic [STATUS_W-1:0]  status_o;
  logic [BASE_W-1:0]    base_page_o;

  int unsigned mismatches;
  int unsigned outstanding;

  typedef struct packed {
    logic [OP_W-1:0]    op;
    logic [COUNT_W-1:0] page_count;
  } request_t;

  typedef struct packed {
    logic [BASE_W-1:0]  base;
    logic [COUNT_W-1:0] page_count;
  } live_run_t;

  // Requests awaiting their result, and runs handed out that may be freed later.
  request_t    requests_in_flight[$];
  live_run_t   live_runs[$];
  int unsigned burst_left;
  int unsigned pages_managed_now;

  always #4 clk_i = ~clk_i;

  first_fit_page_bitmap_allocator #(
    .PAGE_COUNT_MAX(PAGE_COUNT_MAX),
    .MAP_WORD_BITS (32)
  ) DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start_i       (start_i),
    .busy_o        (busy_o),
    .operation_i   (operation_i),
    .start_page_i  (start_page_i),
    .page_count_i  (page_count_i),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_data_i    (cfg_data_i),
    .result_valid_o(result_valid_o),
    .status_o      (status_o),
    .base_page_o   (base_page_o)
  );

  first_fit_page_bitmap_allocator_checker #(
    .PAGE_COUNT_MAX(PAGE_COUNT_MAX)
  ) u_first_fit_check (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start_i       (start_i),
    .busy_i        (busy_o),
    .operation_i   (operation_i),
    .start_page_i  (start_page_i),
    .page_count_i  (page_count_i),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_i   (cfg_ready_o),
    .cfg_data_i    (cfg_data_i),
    .result_valid_i(result_valid_o),
    .status_i      (status_o),
    .base_page_i   (base_page_o),
    .mismatches_o  (mismatches),
    .outstanding_o (outstanding)
  );

  // Track granted runs on the falling edge, where all handshake signals are stable.
  always @(negedge clk_i) begin
    request_t finished;
    if (rst_ni) begin
      if (result_valid_o && requests_in_flight.size() != 0) begin
        finished = requests_in_flight.pop_front();
        if (finished.op == OP_ALLOC && status_o == STATUS_OK) begin
          live_runs.push_back('{base: base_page_o, page_count: finished.page_count});
        end
      end
      if (start_i && !busy_o) begin
        requests_in_flight.push_back('{op: operation_i, page_count: page_count_i});
      end
    end
  end

  function automatic int unsigned pick_burst();
    if ($urandom_range(0, 3) == 0) return $urandom_range(20, 60);
    return $urandom_range(1, 8);
  endfunction

  function automatic int unsigned pick_gap();
    if ($urandom_range(0, 6) == 0) return $urandom_range(7, 300);
    return $urandom_range(1, 6);
  endfunction

  // Mostly small runs, now and then a zero count or one as large as the map.
  function automatic int unsigned pick_count(input int unsigned limit);
    int unsigned pick;
    int unsigned span;
    pick = $urandom_range(0, 99);
    span = (limit == 0) ? PAGE_COUNT_MAX : limit;
    if (pick < 3) return 0;
    if (pick < 75) return $urandom_range(1, (span < 16) ? span : 16);
    if (pick < 92) return $urandom_range(1, (span < 64) ? span : 64);
    if (pick < 98) return $urandom_range(1, span);
    return $urandom_range(0, PAGE_COUNT_MAX);
  endfunction

  // Holds a request until its transfer, then keeps start high or opens a gap.
  task automatic issue_request(input logic [OP_W-1:0] op, input int unsigned first_page,
                               input int unsigned page_count);
    start_i      <= 1'b1;
    operation_i  <= op;
    start_page_i <= first_page[START_W-1:0];
    page_count_i <= page_count[COUNT_W-1:0];
    do @(posedge clk_i); while (busy_o);
    if (burst_left > 0) burst_left--;
    if (burst_left == 0) begin
      start_i <= 1'b0;
      repeat (pick_gap()) @(posedge clk_i);
      burst_left = pick_burst();
    end
  endtask

  // Stops the sender until every predicted result has come back.
  task automatic drain_results();
    if (start_i) start_i <= 1'b0;
    do @(posedge clk_i); while (outstanding != 0 || busy_o);
  endtask

  task automatic set_pages_managed(input int unsigned value);
    drain_results();
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= value[MANAGED_W-1:0];
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    pages_managed_now = value;
  endtask

  // Allocates with random sizes and frees granted runs, with some stray frees as noise.
  task automatic random_traffic(input int unsigned items);
    live_run_t   victim;
    int unsigned victim_index;
    int unsigned choice;
    int unsigned limit;
    int unsigned first_page;
    limit = (pages_managed_now > PAGE_COUNT_MAX) ? PAGE_COUNT_MAX : pages_managed_now;
    repeat (items) begin
      choice = $urandom_range(0, 99);
      if (choice < 40 && live_runs.size() != 0) begin
        victim_index = $urandom_range(0, live_runs.size() - 1);
        victim       = live_runs[victim_index];
        live_runs.delete(victim_index);
        issue_request(OP_FREE, victim.base, victim.page_count);
      end else if (choice < 48) begin
        if (limit != 0 && $urandom_range(0, 3) != 0) first_page = $urandom_range(0, limit - 1);
        else first_page = $urandom_range(0, PAGE_COUNT_MAX - 1);
        issue_request(OP_FREE, first_page, pick_count(limit));
      end else if (choice < 49) begin
        live_runs.delete();
        issue_request(OP_FREE, 0, PAGE_COUNT_MAX);
      end else begin
        issue_request(OP_ALLOC, $urandom_range(0, PAGE_COUNT_MAX - 1), pick_count(limit));
      end
      if ($urandom_range(0, 39) == 0) drain_results();
    end
  endtask

  initial begin
    rst_ni            = 1'b0;
    start_i           = 1'b0;
    operation_i       = OP_ALLOC;
    start_page_i      = '0;
    page_count_i      = '0;
    cfg_valid_i       = 1'b0;
    cfg_data_i        = '0;
    burst_left        = 1;
    pages_managed_now = MANAGED_RESET;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    // Directed checks at the reset page count, starting from an all-free map.
    issue_request(OP_ALLOC, 0, 0);           // zero count with free pages
    issue_request(OP_ALLOC, 0, 1);           // lands on page 0
    issue_request(OP_ALLOC, 0, 4096);        // no run long enough
    issue_request(OP_FREE, 0, 1);
    issue_request(OP_ALLOC, 4095, 4096);     // whole map in one run
    issue_request(OP_ALLOC, 0, 1);           // map full
    issue_request(OP_ALLOC, 0, 0);           // map full wins over zero count
    issue_request(OP_FREE, 4095, 4096);      // clipped at the managed count
    issue_request(OP_FREE, 100, 0);          // clears nothing
    issue_request(OP_ALLOC, 0, 2);           // only one page free
    issue_request(OP_ALLOC, 0, 1);           // takes the last page
    issue_request(OP_FREE, 0, 4096);
    issue_request(OP_ALLOC, 0, 3);
    issue_request(OP_ALLOC, 0, 5);
    issue_request(OP_FREE, 1, 1);            // one-page hole
    issue_request(OP_ALLOC, 0, 2);           // skips the hole
    issue_request(OP_ALLOC, 0, 1);           // fills the hole
    issue_request(OP_ALLOC, 0, 4086);        // ends exactly at the top
    issue_request(OP_FREE, 2048, 2048);
    issue_request(OP_ALLOC, 0, 2048);
    issue_request(OP_FREE, 0, 4096);

    // Random phases over several managed page counts, extremes included.
    set_pages_managed(37);
    random_traffic(150);
    set_pages_managed(0);
    random_traffic(40);
    set_pages_managed(1);
    random_traffic(60);
    set_pages_managed(8191);
    random_traffic(150);
    set_pages_managed(4096);
    random_traffic(650);
    set_pages_managed(200);
    random_traffic(100);

    drain_results();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  // Watchdog far beyond the slowest correct run.
  initial begin
    #20_000_000;
    $display("*** FAILED ***");
    $finish;
  end

endmodule

>>> sim.f
hdl/ffpa_pkg.sv
hdl/ffpa_map_ram.sv
hdl/ffpa_word_scan.sv
hdl/first_fit_page_bitmap_allocator.sv
hdl/ffpa_checker.sv
sim/first_fit_page_bitmap_allocator_checker.sv
sim/first_fit_page_bitmap_allocator_tb.sv
